// ===== design/greedy_direction_next_hop_unit_assert.svh =====
// Assertion macros for the greedy next-hop unit.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef GREEDY_DIRECTION_NEXT_HOP_UNIT_ASSERT_SVH
`define GREEDY_DIRECTION_NEXT_HOP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge out of reset.
`define GDNH_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed")

// Check a consequent in the same cycle as its antecedent.
`define GDNH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed")

// Check a consequent in the cycle after its antecedent.
`define GDNH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed")

`else

`define GDNH_ASSERT(lbl, cond)
`define GDNH_ASSERT_IMPL(lbl, ante, cons)
`define GDNH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/gdnh_pkg.sv =====
// Shared widths, types and the multiplier control word of the next-hop unit.
// No dependencies.
`default_nettype none

package gdnh_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAX_EDGES  = 16;

    // One coordinate difference, also the digit size of the wide products.
    localparam int DIG_W  = COORD_BITS + 1;
    localparam int OPD_W  = DIG_W + 1;
    localparam int PROD_W = 2 * OPD_W;
    localparam int DOT_W  = 2 * DIG_W + 1;
    localparam int MAG_W  = 2 * DIG_W;
    localparam int SQ_W   = 4 * DIG_W;
    localparam int ACC_W  = 6 * DIG_W;
    localparam int POS_W  = $clog2(MAX_EDGES);
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int INDEX_W = 4;
    localparam int SH_W   = 3;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIG_W-1:0]      t_diff;

    // One multiply-accumulate request.
    typedef struct packed {
        logic            en;
        logic            clr;
        logic [SH_W-1:0] sh;
    } t_mac_op;

endpackage

`default_nettype wire

// ===== design/gdnh_if.sv =====
// Valid/ready channels of the next-hop unit: edge words in, result words out.
// Depends on gdnh_pkg.
`default_nettype none

interface gdnh_in_if import gdnh_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord node_x;
    t_coord node_y;
    t_coord goal_x;
    t_coord goal_y;
    t_coord neighbor_x;
    t_coord neighbor_y;
    logic   neighbor_valid;
    logic   last_neighbor;

    modport source (
        output valid, node_x, node_y, goal_x, goal_y,
               neighbor_x, neighbor_y, neighbor_valid, last_neighbor,
        input  ready
    );
    modport sink (
        input  valid, node_x, node_y, goal_x, goal_y,
               neighbor_x, neighbor_y, neighbor_valid, last_neighbor,
        output ready
    );
endinterface

interface gdnh_out_if import gdnh_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] best_index;
    logic               stuck;

    modport source (output valid, best_index, stuck, input ready);
    modport sink (input valid, best_index, stuck, output ready);
endinterface

`default_nettype wire

// ===== design/gdnh_mac.sv =====
// Shared signed multiply-accumulate unit with a digit-shifted accumulator.
// Depends on gdnh_pkg.
`default_nettype none

module gdnh_mac import gdnh_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_op                 i_op,
    input  logic signed [OPD_W-1:0] i_a,
    input  logic signed [OPD_W-1:0] i_b,
    output logic [ACC_W-1:0]        o_acc
);

    logic                     r_pv;
    logic                     r_pclr;
    logic [SH_W-1:0]          r_psh;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         term_ext;
    logic [ACC_W-1:0]         term;

    // Sign-extend the held product, then move it up by whole digits.
    assign term_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign term     = term_ext << (r_psh * DIG_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_op.en;
        end
    end

    // Register the product before the wide add.
    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_prod <= i_a * i_b;
            r_pclr <= i_op.clr;
            r_psh  <= i_op.sh;
        end
        if (r_pv) begin
            r_acc <= (r_pclr ? '0 : r_acc) + term;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== design/greedy_direction_next_hop_unit.sv =====
// Greedy next-hop selector: top level with the pass sequencer and run state.
// Depends on gdnh_pkg, gdnh_if, gdnh_mac and the assertion macro header.
//
// Feed one word per outgoing edge of a node; each word carries the node, the
// goal and the neighbor at the end of the edge. The unit forms g = goal - node
// and e = neighbor - node and keeps the edge with the largest positive cosine
// between them, compared exactly as dot_a^2 * |e_b|^2 > dot_b^2 * |e_a|^2, the
// first of equal edges winning. The word marked last_neighbor produces one
// result word: the run position of the winner, or stuck = 1 with index 0 when
// no edge pointed toward the goal. Only the first MAX_EDGES valid neighbors of
// a run count. All arithmetic runs through one 18x18 signed multiplier with
// a 102-bit digit-shifted accumulator, in passes of issue, drain and store.
// A counted edge runs only the dot and length passes when it cannot
// displace an earlier winner or is the first winner, and the full
// cross-multiplied compare as well when it can (two squarings of 4 steps
// and two wide products of 8 steps). A last word then loads the result
// register; the unit takes the next word while that result waits, and
// holds only if a second result is ready before the first has been taken.
`default_nettype none
`include "greedy_direction_next_hop_unit_assert.svh"

module greedy_direction_next_hop_unit import gdnh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gdnh_in_if.sink     i_in,
    gdnh_out_if.source  o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_STORE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        P_DOT,
        P_LEN,
        P_SQ1,
        P_LHS,
        P_SQ2,
        P_RHS
    } t_pass;

    localparam logic [2:0] K_PAIR = 3'd1;
    localparam logic [2:0] K_SQ   = 3'd3;
    localparam logic [2:0] K_WIDE = 3'd7;

    function automatic t_diff sx(input t_coord v);
        sx = {v[COORD_BITS-1], v};
    endfunction

    function automatic logic signed [OPD_W-1:0] sx_opd(input t_diff v);
        sx_opd = {v[DIG_W-1], v};
    endfunction

    t_state r_state, n_state;
    t_pass  r_pass, n_pass;
    logic [2:0] r_k, n_k;

    // Current edge
    t_diff r_gx, r_gy, r_ex, r_ey;
    t_diff n_gx, n_gy, n_ex, n_ey;
    logic             r_last, n_last;
    logic [POS_W-1:0] r_cur_pos, n_cur_pos;
    logic signed [DOT_W-1:0] r_dot, n_dot;
    logic [MAG_W-1:0] r_len, n_len;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [ACC_W-1:0] r_lhs, n_lhs;

    // Run state
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0] r_best_dot, n_best_dot;
    logic [MAG_W-1:0] r_best_len, n_best_len;
    logic [POS_W-1:0] r_best_pos, n_best_pos;
    logic             r_found, n_found;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic [INDEX_W-1:0] r_out_index, n_out_index;
    logic               r_out_stuck, n_out_stuck;

    logic             accept;
    logic             counted;
    logic             emit_fire;
    logic             dot_pos;
    logic [2:0]       last_k;
    logic [1:0]       dig_i;
    logic             dig_j;
    logic [SQ_W-1:0]  wide_a;
    logic [MAG_W-1:0] wide_b;
    t_mac_op          mac_op;
    logic signed [OPD_W-1:0] opd_a, opd_b;
    logic [ACC_W-1:0] acc;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign counted    = i_in.neighbor_valid && (r_cnt < CNT_W'(MAX_EDGES));
    assign emit_fire  = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign dot_pos    = !r_dot[DOT_W-1] && (r_dot != '0);

    // Digit order for wide passes: B digit fastest, then A digit.
    assign dig_i = r_k[2:1];
    assign dig_j = r_k[0];

    always_comb begin
        wide_a = '0;
        wide_b = '0;
        last_k = K_WIDE;
        case (r_pass)
            P_DOT, P_LEN: begin
                last_k = K_PAIR;
            end
            P_SQ1: begin
                wide_a = SQ_W'(r_dot[MAG_W-1:0]);
                wide_b = r_dot[MAG_W-1:0];
                last_k = K_SQ;
            end
            P_LHS: begin
                wide_a = r_sq;
                wide_b = r_best_len;
            end
            P_SQ2: begin
                wide_a = SQ_W'(r_best_dot);
                wide_b = r_best_dot;
                last_k = K_SQ;
            end
            P_RHS: begin
                wide_a = r_sq;
                wide_b = r_len;
            end
            default: begin
                last_k = K_PAIR;
            end
        endcase
    end

    // Operand select for the shared multiplier
    always_comb begin
        mac_op.en  = (r_state == S_ISSUE);
        mac_op.clr = (r_k == '0);
        mac_op.sh  = SH_W'(dig_i) + SH_W'(dig_j);
        opd_a      = {1'b0, wide_a[dig_i*DIG_W +: DIG_W]};
        opd_b      = {1'b0, wide_b[dig_j*DIG_W +: DIG_W]};
        case (r_pass)
            P_DOT: begin
                mac_op.sh = '0;
                opd_a     = r_k[0] ? sx_opd(r_gy) : sx_opd(r_gx);
                opd_b     = r_k[0] ? sx_opd(r_ey) : sx_opd(r_ex);
            end
            P_LEN: begin
                mac_op.sh = '0;
                opd_a     = r_k[0] ? sx_opd(r_ey) : sx_opd(r_ex);
                opd_b     = opd_a;
            end
            default: begin
            end
        endcase
    end

    gdnh_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_a     (opd_a),
        .i_b     (opd_b),
        .o_acc   (acc)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_k         = r_k;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_ex        = r_ex;
        n_ey        = r_ey;
        n_last      = r_last;
        n_cur_pos   = r_cur_pos;
        n_dot       = r_dot;
        n_len       = r_len;
        n_sq        = r_sq;
        n_lhs       = r_lhs;
        n_cnt       = r_cnt;
        n_best_dot  = r_best_dot;
        n_best_len  = r_best_len;
        n_best_pos  = r_best_pos;
        n_found     = r_found;
        n_out_index = r_out_index;
        n_out_stuck = r_out_stuck;
        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_gx      = sx(i_in.goal_x) - sx(i_in.node_x);
                    n_gy      = sx(i_in.goal_y) - sx(i_in.node_y);
                    n_ex      = sx(i_in.neighbor_x) - sx(i_in.node_x);
                    n_ey      = sx(i_in.neighbor_y) - sx(i_in.node_y);
                    n_last    = i_in.last_neighbor;
                    n_cur_pos = r_cnt[POS_W-1:0];
                    if (counted) begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_pass  = P_DOT;
                        n_k     = '0;
                        n_state = S_ISSUE;
                    end else if (i_in.last_neighbor) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_ISSUE: begin
                if (r_k == last_k) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                // Start the next pass unless the item finishes below.
                n_k     = '0;
                n_state = S_ISSUE;
                case (r_pass)
                    P_DOT: begin
                        n_dot  = acc[DOT_W-1:0];
                        n_pass = P_LEN;
                    end
                    P_LEN: begin
                        n_len = acc[MAG_W-1:0];
                        if (dot_pos && r_found) begin
                            n_pass = P_SQ1;
                        end else begin
                            n_state = r_last ? S_EMIT : S_IDLE;
                            if (dot_pos) begin
                                n_best_dot = r_dot[MAG_W-1:0];
                                n_best_len = acc[MAG_W-1:0];
                                n_best_pos = r_cur_pos;
                                n_found    = 1'b1;
                            end
                        end
                    end
                    P_SQ1: begin
                        n_sq   = acc[SQ_W-1:0];
                        n_pass = P_LHS;
                    end
                    P_LHS: begin
                        n_lhs  = acc;
                        n_pass = P_SQ2;
                    end
                    P_SQ2: begin
                        n_sq   = acc[SQ_W-1:0];
                        n_pass = P_RHS;
                    end
                    P_RHS: begin
                        n_state = r_last ? S_EMIT : S_IDLE;
                        // Strict compare keeps the earlier edge on a tie.
                        if (r_lhs > acc) begin
                            n_best_dot = r_dot[MAG_W-1:0];
                            n_best_len = r_len;
                            n_best_pos = r_cur_pos;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EMIT: begin
                // Hold until the result register is free, then clear the run.
                if (emit_fire) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_found ? INDEX_W'(r_best_pos) : '0;
                    n_out_stuck = !r_found;
                    n_cnt       = '0;
                    n_best_dot  = '0;
                    n_best_len  = '0;
                    n_best_pos  = '0;
                    n_found     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= P_DOT;
            r_k         <= '0;
            r_cnt       <= '0;
            r_best_dot  <= '0;
            r_best_len  <= '0;
            r_best_pos  <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
            r_best_dot  <= n_best_dot;
            r_best_len  <= n_best_len;
            r_best_pos  <= n_best_pos;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx        <= n_gx;
        r_gy        <= n_gy;
        r_ex        <= n_ex;
        r_ey        <= n_ey;
        r_last      <= n_last;
        r_cur_pos   <= n_cur_pos;
        r_dot       <= n_dot;
        r_len       <= n_len;
        r_sq        <= n_sq;
        r_lhs       <= n_lhs;
        r_out_index <= n_out_index;
        r_out_stuck <= n_out_stuck;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.best_index = r_out_index;
    assign o_out.stuck      = r_out_stuck;

    `GDNH_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MAX_EDGES));
    `GDNH_ASSERT_IMPL(a_pos_clear, !r_found, r_best_pos == '0);
    `GDNH_ASSERT_IMPL(a_found_dot, r_found, r_best_dot != '0);
    `GDNH_ASSERT_NEXT(a_emit_out, (r_state == S_EMIT) && !r_out_valid, o_out.valid);

endmodule

`default_nettype wire
